FILE: hdl/spq_pkg.sv
package spq_pkg;

  // storage geometry
  localparam int unsigned Depth = 16;
  localparam int unsigned Width = 32;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned IdxW  = $clog2(Depth);

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [Width-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: hdl/spq_cell.sv
module spq_cell (
  input  logic                            clk_i,
  input  spq_pkg::cell_ctrl_t             ctrl_i,
  input  logic                            occupied_i,
  input  logic                            tail_i,
  input  logic signed [spq_pkg::Width-1:0] left_entry_i,
  input  logic                            left_gt_i,
  input  logic signed [spq_pkg::Width-1:0] right_entry_i,
  output logic signed [spq_pkg::Width-1:0] entry_o,
  output logic                            gt_o
);
  import spq_pkg::*;

  logic signed [Width-1:0] entry_q, entry_d;

  // stored entry is greater than the value being pushed
  assign gt_o    = occupied_i && (entry_q > ctrl_i.value);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (left_gt_i) begin
        // insertion point is to the left, shift right
        entry_d = left_entry_i;
      end else if (gt_o || tail_i) begin
        // first greater entry or the free slot takes the new value
        entry_d = ctrl_i.value;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: hdl/sorted_priority_queue_top.sv
// Sorted priority queue of up to Depth signed values, kept in ascending order in
// a row of cells. A push inserts after all stored values that are not greater,
// so equal values leave in arrival order; a pop returns the smallest value; a
// read returns the value at a position without changing anything. Each input
// transaction gives exactly one result transaction carrying the count after it
// and a status (ok, push dropped because full, pop from empty, index out of
// range). Action code 3 is ignored and reports ok with the current count.
// Throughput is one transaction per clock while results are taken: every cell
// compares its entry with the pushed value in parallel and shifts with its
// neighbor in the same cycle, so the whole array updates at once. The output
// register shows each result in the cycle after its transaction; input ready
// is high whenever that register is empty or being drained in the same cycle.
// No clearing is needed after reset: only positions below the count are read.
module sorted_priority_queue_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  input  logic signed [spq_pkg::Width-1:0] value_i,
  input  logic [spq_pkg::IdxW-1:0]        index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [spq_pkg::Width-1:0] result_value_o,
  output logic [spq_pkg::CntW-1:0]        count_o,
  output logic [1:0]                      status_o
);
  import spq_pkg::*;

  // occupancy of the cell chain
  logic [CntW-1:0] cnt_q, cnt_d;

  // output register
  logic                    out_valid_q;
  logic signed [Width-1:0] res_value_q;
  logic [CntW-1:0]         res_count_q;
  status_e                 res_status_q;

  // item decode
  action_e                 act;
  logic                    in_fire;
  logic                    push_en, pop_en;
  logic signed [Width-1:0] res_value_d;
  status_e                 res_status_d;
  cell_ctrl_t              ctrl;

  // chain wiring
  logic signed [Width-1:0] entry_w [Depth];
  logic [Depth-1:0]        gt_w;

  assign act        = action_e'(action_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // one decision per transaction, taken on the state before it
  always_comb begin
    cnt_d        = cnt_q;
    push_en      = 1'b0;
    pop_en       = 1'b0;
    res_value_d  = '0;
    res_status_d = ST_OK;
    unique case (act)
      ACT_PUSH: begin
        if (cnt_q == CntW'(Depth)) begin
          res_status_d = ST_FULL;
        end else begin
          push_en = 1'b1;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ACT_POP: begin
        if (cnt_q == '0) begin
          res_status_d = ST_EMPTY;
        end else begin
          pop_en      = 1'b1;
          res_value_d = entry_w[0];
          cnt_d       = cnt_q - 1'b1;
        end
      end
      ACT_READ: begin
        if (CntW'(index_i) >= cnt_q) begin
          res_status_d = ST_RANGE;
        end else begin
          res_value_d = entry_w[index_i];
        end
      end
      ACT_NOP: begin
      end
    endcase
  end

  assign ctrl.push  = push_en && in_fire;
  assign ctrl.pop   = pop_en && in_fire;
  assign ctrl.value = value_i;

  // row of cells, head (smallest) at position zero
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [Width-1:0] left_entry, right_entry;
    logic                    left_gt;

    if (i == 0) begin : g_head
      assign left_entry = value_i;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = entry_w[i-1];
      assign left_gt    = gt_w[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_inner
      assign right_entry = entry_w[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (CntW'(i) < cnt_q),
      .tail_i        (CntW'(i) == cnt_q),
      .left_entry_i  (left_entry),
      .left_gt_i     (left_gt),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[i]),
      .gt_o          (gt_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_q <= cnt_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_value_q  <= res_value_d;
      res_count_q  <= cnt_d;
      res_status_q <= res_status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_value_q;
  assign count_o        = res_count_q;
  assign status_o       = res_status_q;

  // occupancy never exceeds the number of cells
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("entry count above depth");

  // the two smallest entries stay in order
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q >= CntW'(2) |-> entry_w[0] <= entry_w[1])
    else $error("head entries out of order");

  // an accepted push with room grows the queue by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not grow the queue");

  // a full-queue result always reports a full count
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == CntW'(Depth))
    else $error("full status with count below depth");

  // an accepted transaction always leaves a result waiting
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction produced no result");

endmodule
